>>> rtl/cvc_pkg.sv
// Shared constants, derived widths and the stage word type of the compass vector conditioner.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cvc_pkg;

  // Block configuration.
  localparam int SCREEN_HEIGHT = 128;
  localparam int CAL_ROUNDS    = 1;

  // Fixed field constants.
  localparam int RAW_W       = 16;
  localparam int FIELD_W     = 10;
  localparam int MAG_W       = 19;
  localparam int OUT_POS_W   = 8;
  localparam int FIELD_MAX   = 450;
  localparam int RANGE_LIMIT = FIELD_MAX * FIELD_MAX;
  localparam int GLYPH_DX    = 6;
  localparam int GLYPH_DY    = 12;

  // Calibration: running sums over CAL_SAMPLES words, mean by reciprocal multiply.
  // The sum magnitude is first shifted down by three (the factor eight), then
  // divided by CAL_ROUNDS with an exact rounded-up reciprocal.
  localparam int CAL_SAMPLES = 8 * CAL_ROUNDS;
  localparam int CNT_W       = $clog2(CAL_SAMPLES);
  localparam int SUM_W       = RAW_W + CNT_W;
  localparam int CAL_A_W     = SUM_W - 3;
  localparam int CAL_SHIFT   = CAL_A_W + $clog2(CAL_ROUNDS);
  localparam int CAL_M_W     = CAL_A_W + 1;
  localparam int CAL_P_W     = CAL_A_W + CAL_M_W;
  localparam longint unsigned CAL_RECIP =
    ((64'd1 << CAL_SHIFT) + CAL_ROUNDS - 1) / CAL_ROUNDS;

  // Scaling by SCALE_NUM / SCALE_DEN, truncated, as magnitude times reciprocal.
  localparam int SCALE_NUM   = 1024;
  localparam int SCALE_DEN   = 7004;
  localparam int SCALE_SHIFT = RAW_W + $clog2(SCALE_NUM) + $clog2(SCALE_DEN);
  localparam int SCALE_M_W   = SCALE_SHIFT - $clog2(SCALE_DEN) + 1;
  localparam int SCALE_POST  = SCALE_SHIFT - $clog2(SCALE_NUM);
  localparam int SCALE_P_W   = RAW_W + SCALE_M_W;
  localparam int SCALE_Q_W   = RAW_W + $clog2(SCALE_NUM) - $clog2(SCALE_DEN) + 1;
  localparam longint unsigned SCALE_RECIP =
    ((64'd1 << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;

  // Screen mapping: (offset field) * (SCREEN_HEIGHT - 1) / (2 * FIELD_MAX).
  localparam int POS_DEN   = 2 * FIELD_MAX;
  localparam int SPAN_W    = $clog2(POS_DEN + 1);
  localparam int POS_Q_W   = $clog2(SCREEN_HEIGHT);
  localparam int POS_W     = POS_Q_W + 1;
  localparam int NUM_W     = SPAN_W + POS_Q_W;
  localparam int POS_SHIFT = NUM_W + $clog2(POS_DEN);
  localparam int POS_M_W   = POS_SHIFT - $clog2(POS_DEN) + 1;
  localparam int POS_P_W   = NUM_W + POS_M_W;
  localparam longint unsigned POS_RECIP =
    ((64'd1 << POS_SHIFT) + POS_DEN - 1) / POS_DEN;

  // One vector word moving between pipeline stages.
  typedef struct packed {
    logic                      valid;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
  } vec_t;

endpackage

`default_nettype wire

>>> rtl/compass_vector_conditioner.sv
// Top level of the compass vector conditioner: input register, stage load control, assertions.
// Depends on cvc_pkg and instantiates cvc_condition, cvc_filter and cvc_locate.
//
//   Channel   Direction  Handshake                     Payload
//   sample    in         sample_valid / sample_stall   kind, raw_x, raw_y
//   result    out        result_valid / result_stall   filt_x, filt_y, mag_squared,
//                                                       pos_x, pos_y, old_x, old_y,
//                                                       in_range, redraw
//
// The block is a five-register pipeline: input register, conditioning, filter, mapping
// and result register. An accepted word passes through them in that order; one word is
// taken each cycle while result_stall is low; each multiplication is followed by a register,
// which sets the depth. Calibration words update the offsets in the conditioning stage
// and produce no result. Reset clears all valid bits, offsets, calibration progress,
// filter history and the last drawn position. When result_stall holds the result
// register, empty stages upstream still fill, and sample_stall rises only once every
// stage holds a word.
`default_nettype none

module compass_vector_conditioner
  import cvc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic                        kind,
  input  logic signed [RAW_W-1:0]     raw_x,
  input  logic signed [RAW_W-1:0]     raw_y,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [FIELD_W-1:0]   filt_x,
  output logic signed [FIELD_W-1:0]   filt_y,
  output logic [MAG_W-1:0]            mag_squared,
  output logic signed [OUT_POS_W-1:0] pos_x,
  output logic signed [OUT_POS_W-1:0] pos_y,
  output logic signed [OUT_POS_W-1:0] old_x,
  output logic signed [OUT_POS_W-1:0] old_y,
  output logic                        in_range,
  output logic                        redraw
);

  // Input register.
  logic                    in_valid;
  logic                    in_kind;
  logic signed [RAW_W-1:0] in_raw_x;
  logic signed [RAW_W-1:0] in_raw_y;

  // Stage words and valid bits.
  vec_t cond_vec;
  vec_t filt_vec;
  logic map_valid;

  // A stage loads when it is empty or when the stage after it loads in the same cycle.
  logic ld_in;
  logic ld_cond;
  logic ld_filt;
  logic ld_map;
  logic ld_out;

  assign ld_out  = !result_valid || !result_stall;
  assign ld_map  = !map_valid || ld_out;
  assign ld_filt = !filt_vec.valid || ld_map;
  assign ld_cond = !cond_vec.valid || ld_filt;
  assign ld_in   = !in_valid || ld_cond;

  assign sample_stall = !ld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ld_in) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in && sample_valid) begin
      in_kind  <= kind;
      in_raw_x <= raw_x;
      in_raw_y <= raw_y;
    end
  end

  cvc_condition u_condition (
    .clk     (clk),
    .rst     (rst),
    .ld      (ld_cond),
    .in_valid(in_valid),
    .kind    (in_kind),
    .raw_x   (in_raw_x),
    .raw_y   (in_raw_y),
    .out_vec (cond_vec)
  );

  cvc_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .ld     (ld_filt),
    .in_vec (cond_vec),
    .out_vec(filt_vec)
  );

  cvc_locate u_locate (
    .clk         (clk),
    .rst         (rst),
    .ld_map      (ld_map),
    .ld_out      (ld_out),
    .in_vec      (filt_vec),
    .map_valid   (map_valid),
    .result_valid(result_valid),
    .filt_x      (filt_x),
    .filt_y      (filt_y),
    .mag_squared (mag_squared),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .old_x       (old_x),
    .old_y       (old_y),
    .in_range    (in_range),
    .redraw      (redraw)
  );

`ifndef SYNTH
  // A redraw is only ever flagged for a vector inside the circle.
  a_redraw_needs_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && redraw |-> in_range)
    else $error("redraw flagged for an out-of-range vector");

  // The range flag agrees with the delivered squared magnitude.
  a_range_matches_mag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (in_range == (mag_squared < MAG_W'(RANGE_LIMIT))))
    else $error("range flag disagrees with squared magnitude");

  // Filtered fields stay within the saturation bounds.
  a_filt_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (filt_x <= FIELD_W'(FIELD_MAX)) && (filt_x >= -FIELD_W'(FIELD_MAX)) &&
                     (filt_y <= FIELD_W'(FIELD_MAX)) && (filt_y >= -FIELD_W'(FIELD_MAX)))
    else $error("filtered field outside saturation bounds");

  // With the result side free, every stage drains and the sample side is never held.
  a_free_output_free_input: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !sample_stall)
    else $error("sample side stalled while the result side is free");

  // After a delivered redraw, the next delivered word erases the position just drawn.
  a_old_follows_redraw: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && redraw ##1 result_valid |->
      (old_x == $past(pos_x)) && (old_y == $past(pos_y)))
    else $error("erase position does not match the last drawn position");
`endif

endmodule

`default_nettype wire

>>> rtl/cvc_scale.sv
// Scales one offset-corrected axis by 1024/7004 toward zero and saturates it to +-450.
// Depends on cvc_pkg for the reciprocal constant and widths.
`default_nettype none

module cvc_scale
  import cvc_pkg::*;
(
  input  logic signed [RAW_W-1:0]   diff,
  output logic signed [FIELD_W-1:0] field
);

  logic [RAW_W-1:0]     mag;
  logic [SCALE_P_W-1:0] prod;
  logic [SCALE_Q_W-1:0] quot;
  logic [FIELD_W-1:0]   sat;

  // The most negative input wraps to its own pattern, which reads correctly as unsigned.
  assign mag  = diff[RAW_W-1] ? RAW_W'(-diff) : RAW_W'(diff);
  assign prod = SCALE_P_W'(mag) * SCALE_P_W'(SCALE_RECIP);
  assign quot = SCALE_Q_W'(prod >> SCALE_POST);
  assign sat  = (quot > SCALE_Q_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : FIELD_W'(quot);

  assign field = diff[RAW_W-1] ? -$signed(sat) : $signed(sat);

endmodule

`default_nettype wire

>>> rtl/cvc_condition.sv
// First stage: calibration sums and offsets, offset removal and scaling of measurement words.
// Depends on cvc_pkg and instantiates cvc_scale for each axis.
`default_nettype none

module cvc_condition
  import cvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ld,
  input  logic                    in_valid,
  input  logic                    kind,
  input  logic signed [RAW_W-1:0] raw_x,
  input  logic signed [RAW_W-1:0] raw_y,
  output vec_t                    out_vec
);

  logic signed [RAW_W-1:0]   offset_x;
  logic signed [RAW_W-1:0]   offset_y;
  logic [CNT_W-1:0]          cal_count;
  logic signed [SUM_W-1:0]   cal_sum_x;
  logic signed [SUM_W-1:0]   cal_sum_y;
  logic signed [SUM_W-1:0]   cal_sum_x_next;
  logic signed [SUM_W-1:0]   cal_sum_y_next;
  logic                      cal_done;
  logic signed [RAW_W-1:0]   diff_x;
  logic signed [RAW_W-1:0]   diff_y;
  logic signed [FIELD_W-1:0] scaled_x;
  logic signed [FIELD_W-1:0] scaled_y;

  // Mean of a finished sum, truncated toward zero and wrapped to the raw width.
  function automatic logic signed [RAW_W-1:0] cal_mean(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-1:0]   mag;
    logic [CAL_A_W-1:0] a;
    logic [CAL_P_W-1:0] prod;
    logic [RAW_W-1:0]   q;
    mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    a        = mag[SUM_W-1:3];
    prod     = CAL_P_W'(a) * CAL_P_W'(CAL_RECIP);
    q        = RAW_W'(prod >> CAL_SHIFT);
    cal_mean = sum[SUM_W-1] ? $signed(-q) : $signed(q);
  endfunction

  assign cal_sum_x_next = cal_sum_x + SUM_W'(raw_x);
  assign cal_sum_y_next = cal_sum_y + SUM_W'(raw_y);
  assign cal_done       = (cal_count == CNT_W'(CAL_SAMPLES - 1));

  assign diff_x = raw_x - offset_x;
  assign diff_y = raw_y - offset_y;

  cvc_scale u_scale_x (.diff(diff_x), .field(scaled_x));
  cvc_scale u_scale_y (.diff(diff_y), .field(scaled_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vec.valid <= 1'b0;
      offset_x      <= '0;
      offset_y      <= '0;
      cal_count     <= '0;
      cal_sum_x     <= '0;
      cal_sum_y     <= '0;
    end else if (ld) begin
      out_vec.valid <= in_valid && !kind;
      if (in_valid && kind) begin
        if (cal_done) begin
          offset_x  <= cal_mean(cal_sum_x_next);
          offset_y  <= cal_mean(cal_sum_y_next);
          cal_count <= '0;
          cal_sum_x <= '0;
          cal_sum_y <= '0;
        end else begin
          cal_count <= cal_count + CNT_W'(1);
          cal_sum_x <= cal_sum_x_next;
          cal_sum_y <= cal_sum_y_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld && in_valid && !kind) begin
      out_vec.x <= scaled_x;
      out_vec.y <= scaled_y;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cvc_filter.sv
// Second stage: 1-2-1 smoothing filter over the last three scaled vectors, divided by four.
// Depends on cvc_pkg for the vector word type.
`default_nettype none

module cvc_filter
  import cvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic ld,
  input  vec_t in_vec,
  output vec_t out_vec
);

  logic signed [FIELD_W-1:0] hist_x1;
  logic signed [FIELD_W-1:0] hist_x2;
  logic signed [FIELD_W-1:0] hist_y1;
  logic signed [FIELD_W-1:0] hist_y2;

  // The sum spans +-1800; a negative sum is biased by three so the shift truncates toward zero.
  function automatic logic signed [FIELD_W-1:0] fir121(input logic signed [FIELD_W-1:0] h2,
                                                       input logic signed [FIELD_W-1:0] h1,
                                                       input logic signed [FIELD_W-1:0] s);
    logic signed [FIELD_W+1:0] acc;
    logic signed [FIELD_W+1:0] adj;
    acc    = (FIELD_W+2)'(h2) + ((FIELD_W+2)'(h1) <<< 1) + (FIELD_W+2)'(s);
    adj    = acc[FIELD_W+1] ? acc + (FIELD_W+2)'(3) : acc;
    fir121 = FIELD_W'(adj >>> 2);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vec.valid <= 1'b0;
      hist_x1       <= '0;
      hist_x2       <= '0;
      hist_y1       <= '0;
      hist_y2       <= '0;
    end else if (ld) begin
      out_vec.valid <= in_vec.valid;
      if (in_vec.valid) begin
        hist_x2 <= hist_x1;
        hist_x1 <= in_vec.x;
        hist_y2 <= hist_y1;
        hist_y1 <= in_vec.y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld && in_vec.valid) begin
      out_vec.x <= fir121(hist_x2, hist_x1, in_vec.x);
      out_vec.y <= fir121(hist_y2, hist_y1, in_vec.y);
    end
  end

endmodule

`default_nettype wire

>>> rtl/cvc_locate.sv
// Third and fourth stages: squared magnitude, screen position, range check and redraw flag.
// Depends on cvc_pkg; holds the last drawn position and drives the result register.
`default_nettype none

module cvc_locate
  import cvc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ld_map,
  input  logic                        ld_out,
  input  vec_t                        in_vec,
  output logic                        map_valid,
  output logic                        result_valid,
  output logic signed [FIELD_W-1:0]   filt_x,
  output logic signed [FIELD_W-1:0]   filt_y,
  output logic [MAG_W-1:0]            mag_squared,
  output logic signed [OUT_POS_W-1:0] pos_x,
  output logic signed [OUT_POS_W-1:0] pos_y,
  output logic signed [OUT_POS_W-1:0] old_x,
  output logic signed [OUT_POS_W-1:0] old_y,
  output logic                        in_range,
  output logic                        redraw
);

  // Map stage signals.
  logic signed [FIELD_W:0]     span_x;
  logic signed [FIELD_W:0]     span_y;
  logic signed [2*FIELD_W-1:0] sq_x;
  logic signed [2*FIELD_W-1:0] sq_y;
  logic signed [FIELD_W-1:0]   fx;
  logic signed [FIELD_W-1:0]   fy;
  logic [MAG_W-1:0]            mag;
  logic [NUM_W-1:0]            num_x;
  logic [NUM_W-1:0]            num_y;

  // Output stage signals.
  logic [POS_P_W-1:0]          prod_x;
  logic [POS_P_W-1:0]          prod_y;
  logic [POS_Q_W-1:0]          quot_x;
  logic [POS_Q_W-1:0]          quot_y;
  logic signed [POS_W-1:0]     px_next;
  logic signed [POS_W-1:0]     py_next;
  logic signed [POS_W-1:0]     last_pos_x;
  logic signed [POS_W-1:0]     last_pos_y;
  logic                        in_range_next;
  logic                        redraw_next;

  // Both spans are in 0..900, so the numerators are nonnegative.
  assign span_x = (FIELD_W+1)'(in_vec.x) + (FIELD_W+1)'(FIELD_MAX);
  assign span_y = (FIELD_W+1)'(FIELD_MAX) - (FIELD_W+1)'(in_vec.y);
  assign sq_x   = (2*FIELD_W)'(in_vec.x) * (2*FIELD_W)'(in_vec.x);
  assign sq_y   = (2*FIELD_W)'(in_vec.y) * (2*FIELD_W)'(in_vec.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= 1'b0;
    end else if (ld_map) begin
      map_valid <= in_vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_map && in_vec.valid) begin
      fx    <= in_vec.x;
      fy    <= in_vec.y;
      mag   <= sq_x[MAG_W-1:0] + sq_y[MAG_W-1:0];
      num_x <= NUM_W'(span_x[SPAN_W-1:0]) * NUM_W'(SCREEN_HEIGHT - 1);
      num_y <= NUM_W'(span_y[SPAN_W-1:0]) * NUM_W'(SCREEN_HEIGHT - 1);
    end
  end

  assign prod_x  = POS_P_W'(num_x) * POS_P_W'(POS_RECIP);
  assign prod_y  = POS_P_W'(num_y) * POS_P_W'(POS_RECIP);
  assign quot_x  = POS_Q_W'(prod_x >> POS_SHIFT);
  assign quot_y  = POS_Q_W'(prod_y >> POS_SHIFT);
  assign px_next = $signed({1'b0, quot_x}) - POS_W'(GLYPH_DX);
  assign py_next = $signed({1'b0, quot_y}) - POS_W'(GLYPH_DY);

  assign in_range_next = (mag < MAG_W'(RANGE_LIMIT));
  assign redraw_next   = in_range_next && ((px_next != last_pos_x) || (py_next != last_pos_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      last_pos_x   <= '0;
      last_pos_y   <= '0;
    end else if (ld_out) begin
      result_valid <= map_valid;
      if (map_valid && redraw_next) begin
        last_pos_x <= px_next;
        last_pos_y <= py_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out && map_valid) begin
      filt_x      <= fx;
      filt_y      <= fy;
      mag_squared <= mag;
      pos_x       <= OUT_POS_W'(px_next);
      pos_y       <= OUT_POS_W'(py_next);
      old_x       <= OUT_POS_W'(last_pos_x);
      old_y       <= OUT_POS_W'(last_pos_y);
      in_range    <= in_range_next;
      redraw      <= redraw_next;
    end
  end

endmodule

`default_nettype wire
